[src/ptc_pkg.sv]
package ptc_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_COUNT  = 2'd2;

  localparam int PATTERN_BYTES_W  = 64;
  localparam int PATTERN_LENGTH_W = 4;
  localparam int CAPTURE_COUNT_W  = 7;
  localparam int CAPTURED_INDEX_W = 6;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_FOUND    = 2'd1,
    STATUS_COMPLETE = 2'd2
  } status_t;

endpackage

[src/ptc_in_if.sv]
interface ptc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

[src/ptc_out_if.sv]
interface ptc_out_if;
  logic                                   valid;
  logic                                   ready;
  ptc_pkg::status_t                       status;
  logic                                   captured_valid;
  logic [7:0]                             captured_byte;
  logic [ptc_pkg::CAPTURED_INDEX_W-1:0]   captured_index;
  logic                                   flush_request;

  modport source (output valid, output status, output captured_valid, output captured_byte,
                  output captured_index, output flush_request, input ready);
  modport sink   (input valid, input status, input captured_valid, input captured_byte,
                  input captured_index, input flush_request, output ready);
endinterface

[src/ptc_cfg_if.sv]
interface ptc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ptc_pkg::CFG_IDX_W-1:0]         index;
  logic [ptc_pkg::PATTERN_BYTES_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/pattern_trigger_capture.sv]
// Byte-stream pattern trigger with post-match capture. Each accepted byte is
// compared against the pattern character at the current match position; a
// full match reports status FOUND, then either requests a flush (capture
// count zero) or captures the next capture-count bytes, each emitted with
// its index, the last one with status COMPLETE and a flush request. Every
// accepted byte yields exactly one result, registered at acceptance, from
// a single output register. Throughput is one byte per cycle: the only
// per-byte work is one 8-bit compare plus the match/capture counter update.
// The input is stalled only while the output register holds a result that
// the sink has not taken. Configuration writes are always accepted.
module pattern_trigger_capture #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_CAPTURE = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  ptc_in_if.sink   in_ch,
  ptc_out_if.source out_ch,
  ptc_cfg_if.sink  cfg_ch
);

  localparam int PW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int IW   = (MAX_CAPTURE > 1) ? $clog2(MAX_CAPTURE) : 1;
  localparam int CW   = $clog2(MAX_CAPTURE + 1);
  localparam int CMPW = (CW > ptc_pkg::CAPTURE_COUNT_W) ? CW : ptc_pkg::CAPTURE_COUNT_W;
  localparam int LW   = ptc_pkg::PATTERN_LENGTH_W;

  logic [MAX_PATTERN-1:0][7:0]          pattern_r;
  logic [LW-1:0]                        length_r;
  logic [ptc_pkg::CAPTURE_COUNT_W-1:0]  count_r;

  logic [PW-1:0] match_pos_r, match_pos_nxt;
  logic          capturing_r, capturing_nxt;
  logic [IW-1:0] cap_idx_r, cap_idx_nxt;

  logic                                 out_valid_r;
  ptc_pkg::status_t                     status_r, status_nxt;
  logic                                 cvalid_r, cvalid_nxt;
  logic [7:0]                           cbyte_r, cbyte_nxt;
  logic [ptc_pkg::CAPTURED_INDEX_W-1:0] cidx_r, cidx_nxt;
  logic                                 flush_r, flush_nxt;

  logic            in_fire;
  logic [CW-1:0]   cap_inc;
  logic [CMPW-1:0] cnt_ext, eff_cnt;
  logic [LW-1:0]   pos_inc, eff_len;
  logic [7:0]      want;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.captured_valid = cvalid_r;
  assign out_ch.captured_byte  = cbyte_r;
  assign out_ch.captured_index = cidx_r;
  assign out_ch.flush_request  = flush_r;

  always_comb begin
    cap_inc = CW'(cap_idx_r) + CW'(1);
    cnt_ext = CMPW'(count_r);
    eff_cnt = (cnt_ext > CMPW'(MAX_CAPTURE)) ? CMPW'(MAX_CAPTURE) : cnt_ext;

    pos_inc = LW'(match_pos_r) + LW'(1);
    eff_len = length_r;
    if (eff_len == '0) eff_len = LW'(1);
    if (eff_len > LW'(MAX_PATTERN)) eff_len = LW'(MAX_PATTERN);
    want = pattern_r[match_pos_r];

    match_pos_nxt = match_pos_r;
    capturing_nxt = capturing_r;
    cap_idx_nxt   = cap_idx_r;
    status_nxt    = ptc_pkg::STATUS_NONE;
    cvalid_nxt    = 1'b0;
    cbyte_nxt     = '0;
    cidx_nxt      = '0;
    flush_nxt     = 1'b0;

    if (capturing_r) begin
      cvalid_nxt  = 1'b1;
      cbyte_nxt   = in_ch.data_byte;
      cidx_nxt    = ptc_pkg::CAPTURED_INDEX_W'(cap_idx_r);
      cap_idx_nxt = IW'(cap_inc);
      if (CMPW'(cap_inc) >= eff_cnt) begin
        cap_idx_nxt   = '0;
        capturing_nxt = 1'b0;
        flush_nxt     = 1'b1;
        status_nxt    = ptc_pkg::STATUS_COMPLETE;
      end
    end else if (in_ch.data_byte == want) begin
      if (pos_inc >= eff_len) begin
        match_pos_nxt = '0;
        status_nxt    = ptc_pkg::STATUS_FOUND;
        if (count_r != '0) begin
          capturing_nxt = 1'b1;
          cap_idx_nxt   = '0;
        end else begin
          flush_nxt = 1'b1;
        end
      end else begin
        match_pos_nxt = PW'(pos_inc);
      end
    end else begin
      match_pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= '0;
      length_r    <= LW'(1);
      count_r     <= '0;
      match_pos_r <= '0;
      capturing_r <= 1'b0;
      cap_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          ptc_pkg::CFG_PATTERN_BYTES:  pattern_r <= cfg_ch.data[MAX_PATTERN*8-1:0];
          ptc_pkg::CFG_PATTERN_LENGTH: length_r  <= cfg_ch.data[LW-1:0];
          ptc_pkg::CFG_CAPTURE_COUNT:  count_r   <= cfg_ch.data[ptc_pkg::CAPTURE_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        match_pos_r <= match_pos_nxt;
        capturing_r <= capturing_nxt;
        cap_idx_r   <= cap_idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      cvalid_r <= cvalid_nxt;
      cbyte_r  <= cbyte_nxt;
      cidx_r   <= cidx_nxt;
      flush_r  <= flush_nxt;
    end
  end

  a_capture_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && capturing_r) |=> (out_valid_r && cvalid_r))
    else $error("byte taken during capture not reported as captured");

  a_found_not_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ptc_pkg::STATUS_FOUND) |-> !cvalid_r)
    else $error("found result carries a captured byte");

  a_match_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (PW + 1)'(match_pos_r) < (PW + 1)'(MAX_PATTERN))
    else $error("match position out of range");

  a_cap_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !capturing_r |-> (cap_idx_r == '0))
    else $error("capture index nonzero while not capturing");

endmodule
